// ===== rtl/core/dane_pkg.sv =====
package dane_pkg;

   localparam int VALUE_WIDTH     = 32;
   localparam int DIGIT_COUNT     = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int DIGIT_IDX_WIDTH = $clog2(DIGIT_COUNT);
   localparam int BIT_CNT_WIDTH   = $clog2(VALUE_WIDTH);
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_POINT = 8'd46;
   localparam logic [3:0] DIGIT_NINE = 4'd9;
   localparam logic [3:0] DABBLE_MIN = 4'd5;
   localparam logic [3:0] DABBLE_ADD = 4'd3;
   localparam int         FRAC_DIGITS = 2;

   typedef struct packed {
      logic                   mode;
      logic [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_type;

endpackage

// ===== rtl/core/decimal_ascii_number_emitter_core.sv =====
// Prints an unsigned value as decimal ASCII, most significant digit first with leading
// zeros suppressed, one character per rsp item, last set on the final one. With mode 1 the
// value is hundredths: a '.' goes before the last two digits and values under 100 print
// as "0.0d" or "0.dd". Items enter a two-entry queue; the converter takes one at a time:
// a load step, a bit-serial shift-add-3 conversion over all 32 value bits, a sizing step
// and then one character per cycle (up to 11) while the output is not stalled.
module decimal_ascii_number_emitter_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dane_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dane_pkg::rsp_type rsp_payload
);
   import dane_pkg::*;

   logic    q_valid;
   logic    q_pop;
   req_type q_item;

   dane_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_item      (q_item)
   );

   dane_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_item      (q_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/core/dane_front.sv =====
module dane_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dane_pkg::req_type req_payload,
   output logic             q_valid,
   input  logic             q_pop,
   output dane_pkg::req_type q_item
);
   import dane_pkg::*;

   req_type                    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                       push;
   logic                       pop;

   assign req_stall = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = q_valid && q_pop;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_payload;
      end
   end

endmodule

// ===== rtl/core/dane_back.sv =====
module dane_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  dane_pkg::req_type q_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dane_pkg::rsp_type rsp_payload
);
   import dane_pkg::*;

   typedef enum logic [3:0] {
      IDLE    = 4'b0001,
      CONVERT = 4'b0010,
      SIZE    = 4'b0100,
      EMIT    = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [VALUE_WIDTH-1:0]     shift_ff, shift_in;
   logic [3:0]                 digit_ff [DIGIT_COUNT];
   logic [3:0]                 digit_in [DIGIT_COUNT];
   logic [3:0]                 adj      [DIGIT_COUNT];
   logic [BIT_CNT_WIDTH-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIGIT_IDX_WIDTH-1:0] pos_ff, pos_in;
   logic [DIGIT_IDX_WIDTH-1:0] top;
   logic                       fixed_ff, fixed_in;
   logic                       point_ff, point_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;
   logic                       out_free;
   logic                       emit;

   assign q_pop       = (state_ff == IDLE);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign emit        = (state_ff == EMIT) && out_free;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // shift-and-add-3 lanes
   always_comb begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         adj[k] = (digit_ff[k] >= DABBLE_MIN) ? digit_ff[k] + DABBLE_ADD : digit_ff[k];
      end
   end

   always_comb begin
      top = '0;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         if (digit_ff[k] != '0) begin
            top = DIGIT_IDX_WIDTH'(k);
         end
      end
      if (fixed_ff && top < DIGIT_IDX_WIDTH'(FRAC_DIGITS)) begin
         top = DIGIT_IDX_WIDTH'(FRAC_DIGITS);
      end
   end

   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      digit_in     = digit_ff;
      bit_cnt_in   = bit_cnt_ff;
      pos_in       = pos_ff;
      fixed_in     = fixed_ff;
      point_in     = point_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         IDLE: begin
            if (q_valid) begin
               shift_in   = q_item.value;
               fixed_in   = q_item.mode;
               bit_cnt_in = BIT_CNT_WIDTH'(VALUE_WIDTH - 1);
               for (int k = 0; k < DIGIT_COUNT; k++) begin
                  digit_in[k] = '0;
               end
               state_in = CONVERT;
            end
         end
         CONVERT: begin
            digit_in[0] = {adj[0][2:0], shift_ff[VALUE_WIDTH-1]};
            for (int k = 1; k < DIGIT_COUNT; k++) begin
               digit_in[k] = {adj[k][2:0], adj[k-1][3]};
            end
            shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
            if (bit_cnt_ff == '0) begin
               state_in = SIZE;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         SIZE: begin
            pos_in   = top;
            point_in = 1'b0;
            state_in = EMIT;
         end
         EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (point_ff) begin
                  rsp_in.character = CHAR_POINT;
                  rsp_in.last      = 1'b0;
                  point_in         = 1'b0;
               end else begin
                  rsp_in.character = CHAR_ZERO + {4'b0, digit_ff[pos_ff]};
                  rsp_in.last      = (pos_ff == '0);
                  point_in         = fixed_ff && (pos_ff == DIGIT_IDX_WIDTH'(FRAC_DIGITS));
                  if (pos_ff == '0) begin
                     state_in = IDLE;
                  end else begin
                     pos_in = pos_ff - 1'b1;
                  end
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         point_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         point_ff     <= point_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      digit_ff   <= digit_in;
      bit_cnt_ff <= bit_cnt_in;
      pos_ff     <= pos_in;
      fixed_ff   <= fixed_in;
      rsp_ff     <= rsp_in;
   end

   a_point_fixed: assert property (@(posedge clock) disable iff (reset)
      point_ff |-> fixed_ff)
      else $error("point pending outside fixed mode");

   a_last_digit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last) |->
         (rsp_ff.character >= CHAR_ZERO && rsp_ff.character <= CHAR_ZERO + {4'b0, DIGIT_NINE}))
      else $error("last item is not a digit");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && !point_ff && pos_ff == '0) |=> (state_ff == IDLE && rsp_valid_ff && rsp_ff.last))
      else $error("number did not end with last");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT) |-> (pos_ff < DIGIT_IDX_WIDTH'(DIGIT_COUNT)))
      else $error("digit position out of range");

endmodule
